>>> sv/ctsu_pkg.sv
// ctsu_pkg: shared types, codes and Q32.32 saturating helpers for the
// constant-coefficient tridiagonal solver. Depends on nothing.
`default_nettype none

package ctsu_pkg;

    localparam int VALUE_BITS = 64;
    localparam int FRAC_BITS  = 32;
    localparam int DIV_STEPS  = VALUE_BITS + FRAC_BITS;
    localparam int CFG_IDX_W  = 3;

    typedef logic [VALUE_BITS-1:0] t_value;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result kinds and status
    localparam logic KIND_SOLVED     = 1'b0;
    localparam logic KIND_READ       = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_UNSTABLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SUB       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIAG      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SUPER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUNDARY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IN_USE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_THRESH   = 3'd5;

    typedef struct packed {
        logic               operation;
        logic [10:0]        index;
        logic signed [63:0] rhs_value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic               status;
        logic signed [63:0] solution_value;
    } t_out_item;

    typedef struct packed {
        logic in_take;
        logic fwd_init;
        logic mul_start;
        logic back;
        logic rhs_rd;
        logic take_mul;
        logic div_start;
        logic take_div;
        logic back_rd;
        logic fill_update;
        logic out_load;
        logic out_kind;
        logic out_status;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic pivot_low;
        logic row_last;
        logic i_zero;
    } t_stat;

    localparam t_value MAG_TOP = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam t_value POS_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    function automatic t_value mag(input t_value v);
        return v[VALUE_BITS-1] ? t_value'(0) - v : v;
    endfunction

    // sign and magnitude back to two's complement, saturating
    function automatic t_value sat_make(input logic neg, input t_value m);
        if (neg) begin
            return (m > MAG_TOP) ? MAG_TOP : t_value'(0) - m;
        end
        return (m > POS_MAX) ? POS_MAX : m;
    endfunction

    // saturating a - b
    function automatic t_value sub_q(input t_value a, input t_value b);
        logic              sa;
        logic              sb;
        t_value            ma;
        t_value            mb;
        logic [VALUE_BITS:0] s;
        sa = a[VALUE_BITS-1];
        sb = ~b[VALUE_BITS-1];
        ma = mag(a);
        mb = mag(b);
        if (sa == sb) begin
            s = {1'b0, ma} + {1'b0, mb};
            return sat_make(sa, s[VALUE_BITS] ? '1 : s[VALUE_BITS-1:0]);
        end
        if (ma >= mb) begin
            return sat_make(sa, ma - mb);
        end
        return sat_make(sb, mb - ma);
    endfunction

endpackage

`default_nettype wire

>>> sv/constant_tridiagonal_solver_unit.sv
// Constant-coefficient tridiagonal solver (Thomas algorithm, signed Q32.32).
// A load or a read is taken when the block is idle; a read returns its
// element through the store's read register and the result register, once
// the output is free. The load marked last runs the solve: forward
// elimination of each of the n rows (paced by the 96-step bit-serial
// dividers, two of which run side by side on each pivot), then back
// substitution through the sequential multiplier. No clearing pass is needed
// after reset: the solution store keeps a fill mark. Depends on ctsu_pkg,
// ctsu_ctrl and ctsu_dp.
`default_nettype none

module constant_tridiagonal_solver_unit #(
    parameter int MAX_UNKNOWNS = 2048
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire ctsu_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output ctsu_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ctsu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire ctsu_pkg::t_value               i_cfg_data
);

    ctsu_pkg::t_cmd  cmd;
    ctsu_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    ctsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ctsu_dp #(
        .MAX_UNKNOWNS (MAX_UNKNOWNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> sv/ctsu_mul.sv
// ctsu_mul: sequential Q32.32 saturating multiplier, one 32x32 partial
// product a cycle. Depends on ctsu_pkg.
`default_nettype none

module ctsu_mul (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire ctsu_pkg::t_value i_a,
    input  wire ctsu_pkg::t_value i_b,
    output logic                 o_done,
    output ctsu_pkg::t_value     o_result
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic         r_done;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;

    logic [31:0]  ha;
    logic [31:0]  hb;
    logic [63:0]  prod;
    logic [127:0] add_term;
    logic [63:0]  q;

    always_comb begin
        case (r_cnt)
            3'd0: begin ha = r_ma[31:0];  hb = r_mb[31:0];  end
            3'd1: begin ha = r_ma[31:0];  hb = r_mb[63:32]; end
            3'd2: begin ha = r_ma[63:32]; hb = r_mb[31:0];  end
            default: begin ha = r_ma[63:32]; hb = r_mb[63:32]; end
        endcase
        prod = {32'd0, ha} * {32'd0, hb};
        // product of the previous step, at its weight
        case (r_cnt)
            3'd1: add_term = {64'd0, r_pp};
            3'd2: add_term = {32'd0, r_pp, 32'd0};
            3'd3: add_term = {32'd0, r_pp, 32'd0};
            3'd4: add_term = {r_pp, 64'd0};
            default: add_term = '0;
        endcase
        q = (|r_acc[127:96]) ? '1 : r_acc[95:32];
    end

    assign o_result = ctsu_pkg::sat_make(r_neg, q);
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= ctsu_pkg::mag(i_a);
            r_mb  <= ctsu_pkg::mag(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp  <= prod;
            r_acc <= r_acc + add_term;
        end
    end

endmodule

`default_nettype wire

>>> sv/ctsu_div.sv
// ctsu_div: restoring Q32.32 divider, one quotient bit a cycle, saturating.
// Depends on ctsu_pkg.
`default_nettype none

module ctsu_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire ctsu_pkg::t_value i_a,
    input  wire ctsu_pkg::t_value i_b,
    output logic                  o_done,
    output ctsu_pkg::t_value      o_result
);

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic        r_done;
    logic [95:0] r_num;
    logic [63:0] r_mb;
    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic        r_over;
    logic        r_neg;
    logic        r_zero;

    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        ge;

    always_comb begin
        rem_sh  = {r_rem, r_num[95]};
        rem_sub = rem_sh - {1'b0, r_mb};
        ge      = rem_sh >= {1'b0, r_mb};
    end

    // zero over zero gives zero, any other zero divisor saturates
    assign o_result = r_zero ? '0 : ctsu_pkg::sat_make(r_neg, r_over ? '1 : r_q);
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(ctsu_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {ctsu_pkg::mag(i_a), 32'd0};
            r_mb   <= ctsu_pkg::mag(i_b);
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
            r_neg  <= i_a[63] ^ i_b[63];
            r_zero <= (ctsu_pkg::mag(i_a) == '0) && (ctsu_pkg::mag(i_b) == '0);
        end else if (r_busy) begin
            r_num  <= {r_num[94:0], 1'b0};
            r_rem  <= ge ? rem_sub[63:0] : rem_sh[63:0];
            r_over <= r_over | r_q[63];
            r_q    <= {r_q[62:0], ge};
        end
    end

endmodule

`default_nettype wire

>>> sv/ctsu_dp.sv
// ctsu_dp: solver datapath: configuration registers, the four element
// stores, multipliers, dividers and the result register.
// Depends on ctsu_pkg, ctsu_mul and ctsu_div.
`default_nettype none

module ctsu_dp #(
    parameter int MAX_UNKNOWNS = 2048
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ctsu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire ctsu_pkg::t_value                  i_cfg_data,
    input  wire ctsu_pkg::t_in_item                i_in_item,
    input  wire ctsu_pkg::t_cmd                    i_cmd,
    output ctsu_pkg::t_stat                        o_stat,
    output ctsu_pkg::t_out_item                    o_out_item
);

    localparam int AW = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;

    // configuration
    ctsu_pkg::t_value r_coef_sub;
    ctsu_pkg::t_value r_coef_diag;
    ctsu_pkg::t_value r_coef_super;
    ctsu_pkg::t_value r_lower_bnd;
    logic [11:0]      r_size;
    logic [62:0]      r_thresh;

    // control-side counters
    logic [11:0] r_i;
    logic [11:0] r_n;
    logic [11:0] r_fill;

    // working registers
    ctsu_pkg::t_value r_ratio_prev;
    ctsu_pkg::t_value r_part_prev;
    ctsu_pkg::t_value r_d;
    ctsu_pkg::t_value r_num;
    ctsu_pkg::t_value r_x;
    logic             r_rd_zero;
    ctsu_pkg::t_out_item r_out;

    // stores
    ctsu_pkg::t_value rhs_mem   [MAX_UNKNOWNS];
    ctsu_pkg::t_value ratio_mem [MAX_UNKNOWNS];
    ctsu_pkg::t_value part_mem  [MAX_UNKNOWNS];
    ctsu_pkg::t_value sol_mem   [MAX_UNKNOWNS];
    ctsu_pkg::t_value r_rhs_q;
    ctsu_pkg::t_value r_ratio_q;
    ctsu_pkg::t_value r_part_q;
    ctsu_pkg::t_value r_sol_q;

    logic             in_range;
    logic             rhs_we;
    logic             sol_rd;
    logic             fwd_we;
    logic             sol_we;
    logic [AW-1:0]    sol_wa;
    ctsu_pkg::t_value sol_wd;
    logic [11:0]      n_clamp;
    logic             row_last;

    ctsu_pkg::t_value mul0_a;
    ctsu_pkg::t_value mul0_b;
    ctsu_pkg::t_value mul0_q;
    ctsu_pkg::t_value mul1_q;
    logic             mul0_done;
    logic             mul1_done;
    ctsu_pkg::t_value div0_q;
    ctsu_pkg::t_value div1_q;
    logic             div0_done;
    logic             div1_done;
    ctsu_pkg::t_value x_back;

    always_comb begin
        in_range = 32'(i_in_item.index) < MAX_UNKNOWNS;
        rhs_we   = i_cmd.in_take && (i_in_item.operation == ctsu_pkg::OP_LOAD) && in_range;
        sol_rd   = i_cmd.in_take && (i_in_item.operation == ctsu_pkg::OP_READ);
        n_clamp  = (r_size < 12'd3) ? 12'd3 :
                   ((32'(r_size) > MAX_UNKNOWNS) ? 12'(MAX_UNKNOWNS) : r_size);
        row_last = (r_i == r_n - 12'd1);
        fwd_we   = i_cmd.take_div && !row_last;
        mul0_a   = i_cmd.back ? r_ratio_q : r_coef_sub;
        mul0_b   = i_cmd.back ? r_x : r_ratio_prev;
        x_back   = ctsu_pkg::sub_q(r_part_q, mul0_q);
        // solution is written by the boundary row, then by back substitution
        sol_we   = (i_cmd.take_div && row_last) || (i_cmd.take_mul && i_cmd.back);
        if (i_cmd.back) begin
            sol_wa = AW'(r_i - 12'd1);
            sol_wd = x_back;
        end else begin
            sol_wa = AW'(r_i);
            sol_wd = div1_q;
        end
    end

    ctsu_mul u_mul0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (mul0_a),
        .i_b      (mul0_b),
        .o_done   (mul0_done),
        .o_result (mul0_q)
    );

    ctsu_mul u_mul1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (r_coef_sub),
        .i_b      (r_part_prev),
        .o_done   (mul1_done),
        .o_result (mul1_q)
    );

    ctsu_div u_div0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_a      (r_coef_super),
        .i_b      (r_d),
        .o_done   (div0_done),
        .o_result (div0_q)
    );

    ctsu_div u_div1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_a      (r_num),
        .i_b      (r_d),
        .o_done   (div1_done),
        .o_result (div1_q)
    );

    assign o_stat.mul_done  = mul0_done && (i_cmd.back || mul1_done);
    assign o_stat.div_done  = div0_done && div1_done;
    assign o_stat.pivot_low = {1'b0, ctsu_pkg::mag(r_d)} < {2'b00, r_thresh};
    assign o_stat.row_last  = row_last;
    assign o_stat.i_zero    = (r_i == 12'd0);
    assign o_out_item       = r_out;

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_sub   <= '0;
            r_coef_diag  <= ctsu_pkg::t_value'(1) << ctsu_pkg::FRAC_BITS;
            r_coef_super <= '0;
            r_lower_bnd  <= '0;
            r_size       <= 12'd2048;
            r_thresh     <= 63'd1;
            r_i          <= '0;
            r_n          <= 12'd3;
            r_fill       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ctsu_pkg::CFG_COEF_SUB:       r_coef_sub   <= i_cfg_data;
                    ctsu_pkg::CFG_COEF_DIAG:      r_coef_diag  <= i_cfg_data;
                    ctsu_pkg::CFG_COEF_SUPER:     r_coef_super <= i_cfg_data;
                    ctsu_pkg::CFG_LOWER_BOUNDARY: r_lower_bnd  <= i_cfg_data;
                    ctsu_pkg::CFG_SIZE_IN_USE:    r_size       <= i_cfg_data[11:0];
                    ctsu_pkg::CFG_PIVOT_THRESH:   r_thresh     <= i_cfg_data[62:0];
                    default: ;
                endcase
            end
            if (i_cmd.fwd_init) begin
                r_i <= '0;
                r_n <= n_clamp;
            end else if (fwd_we) begin
                r_i <= r_i + 12'd1;
            end else if (i_cmd.take_mul && i_cmd.back) begin
                r_i <= r_i - 12'd1;
            end
            // solutions always fill a prefix, so a high-water mark stands in for clearing
            if (i_cmd.fill_update && (r_n > r_fill)) begin
                r_fill <= r_n;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.fwd_init) begin
            r_ratio_prev <= '0;
            r_part_prev  <= '0;
        end else if (fwd_we) begin
            r_ratio_prev <= div0_q;
            r_part_prev  <= div1_q;
        end
        if (i_cmd.take_mul && !i_cmd.back) begin
            r_d   <= ctsu_pkg::sub_q(r_coef_diag, mul0_q);
            r_num <= ctsu_pkg::sub_q(row_last ? r_lower_bnd : r_rhs_q, mul1_q);
        end
        if (sol_we) begin
            r_x <= sol_wd;
        end
        if (sol_rd) begin
            r_rd_zero <= !in_range || ({1'b0, i_in_item.index} >= r_fill);
        end
        if (i_cmd.out_load) begin
            r_out.kind   <= i_cmd.out_kind;
            r_out.status <= i_cmd.out_status;
            if (i_cmd.out_kind == ctsu_pkg::KIND_READ && !r_rd_zero) begin
                r_out.solution_value <= r_sol_q;
            end else begin
                r_out.solution_value <= '0;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (rhs_we) begin
            rhs_mem[AW'(i_in_item.index)] <= i_in_item.rhs_value;
        end
        if (i_cmd.rhs_rd) begin
            r_rhs_q <= rhs_mem[AW'(r_i)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            ratio_mem[AW'(r_i)] <= div0_q;
        end
        if (i_cmd.back_rd) begin
            r_ratio_q <= ratio_mem[AW'(r_i - 12'd1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            part_mem[AW'(r_i)] <= div1_q;
        end
        if (i_cmd.back_rd) begin
            r_part_q <= part_mem[AW'(r_i - 12'd1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sol_we) begin
            sol_mem[sol_wa] <= sol_wd;
        end
        if (sol_rd) begin
            r_sol_q <= sol_mem[AW'(i_in_item.index)];
        end
    end

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i < r_n)
        else $error("row counter beyond system size");

    a_fill_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_update |-> (r_i == 12'd0))
        else $error("solve marked complete before back substitution ended");

    a_back_not_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_mul && i_cmd.back) |-> (r_i != 12'd0))
        else $error("back substitution ran past row zero");

endmodule

`default_nettype wire

>>> sv/ctsu_ctrl.sv
// ctsu_ctrl: sequencer for loads, reads, forward elimination and back
// substitution. Depends on ctsu_pkg.
`default_nettype none

module ctsu_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire ctsu_pkg::t_in_item i_in_item,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire ctsu_pkg::t_stat    i_stat,
    output ctsu_pkg::t_cmd          o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_READ   = 10'b00_0000_0010,
        S_F_START = 10'b00_0000_0100,
        S_F_MUL  = 10'b00_0000_1000,
        S_F_CHK  = 10'b00_0001_0000,
        S_F_DIV  = 10'b00_0010_0000,
        S_B_RD   = 10'b00_0100_0000,
        S_B_MUL0 = 10'b00_1000_0000,
        S_B_MUL  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   r_fail;
    logic   n_fail;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_fail      = r_fail;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    if (i_in_item.operation == ctsu_pkg::OP_READ) begin
                        n_state = S_READ;
                    end else if (i_in_item.last) begin
                        o_cmd.fwd_init = 1'b1;
                        n_state        = S_F_START;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = ctsu_pkg::KIND_READ;
                    o_cmd.out_status = ctsu_pkg::STATUS_OK;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_F_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.rhs_rd    = 1'b1;
                n_state         = S_F_MUL;
            end
            S_F_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.take_mul = 1'b1;
                    n_state        = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_stat.pivot_low) begin
                    n_fail  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_F_DIV;
                end
            end
            S_F_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.take_div = 1'b1;
                    n_state        = i_stat.row_last ? S_B_RD : S_F_START;
                end
            end
            S_B_RD: begin
                o_cmd.back = 1'b1;
                if (i_stat.i_zero) begin
                    o_cmd.fill_update = 1'b1;
                    n_fail            = 1'b0;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.back_rd = 1'b1;
                    n_state       = S_B_MUL0;
                end
            end
            S_B_MUL0: begin
                o_cmd.back      = 1'b1;
                o_cmd.mul_start = 1'b1;
                n_state         = S_B_MUL;
            end
            S_B_MUL: begin
                o_cmd.back = 1'b1;
                if (i_stat.mul_done) begin
                    o_cmd.take_mul = 1'b1;
                    n_state        = S_B_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = ctsu_pkg::KIND_SOLVED;
                    o_cmd.out_status = r_fail ? ctsu_pkg::STATUS_UNSTABLE
                                              : ctsu_pkg::STATUS_OK;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fail      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fail      <= n_fail;
        end
    end

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> (r_state == S_F_MUL || r_state == S_B_MUL))
        else $error("multiplier finished outside a multiply wait");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_F_DIV))
        else $error("divider finished outside a divide wait");

    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result loaded without returning to idle");

endmodule

`default_nettype wire

>>> dv/tb_constant_tridiagonal_solver_unit.sv
// Self-checking testbench for constant_tridiagonal_solver_unit: directed table then random
// load/solve/read traffic, each result checked against a fixed table entry or a Q32.32
// Thomas-algorithm predictor. Depends on ctsu_pkg and the solver RTL.
`timescale 1ns / 1ps

module tb_constant_tridiagonal_solver_unit;

    localparam int NMAX = 2048;
    typedef logic [63:0] t_q;

    typedef struct packed {
        logic                  is_cfg;
        logic [2:0]            cfg_idx;
        t_q                    cfg_data;
        ctsu_pkg::t_in_item    item;
        logic                  typed;
        ctsu_pkg::t_out_item   res;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    ctsu_pkg::t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      cfg_valid = 1'b0;
    logic [2:0] cfg_idx = '0;
    t_q        cfg_data = '0;
    logic      in_ready, out_valid, cfg_ready;
    ctsu_pkg::t_out_item out_item;

    constant_tridiagonal_solver_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the block's registers and stores
    t_q   m_sub, m_diag, m_super, m_bound;
    logic [11:0] m_size;
    logic [62:0] m_thresh;
    t_q   rhs_mem[NMAX];
    t_q   ratio_mem[NMAX];
    t_q   partial_mem[NMAX];
    t_q   sol_mem[NMAX];
    bit   rhs_written[NMAX];

    ctsu_pkg::t_out_item pending_results[$];
    t_row      stim_table[$];
    int  fail_count = 0;
    int  rand_items = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0;

    function automatic t_q q_mag(t_q v);
        return v[63] ? t_q'(0) - v : v;
    endfunction

    function automatic t_q q_pack(logic neg, t_q m);
        t_q top;
        top = 64'h8000_0000_0000_0000;
        if (neg) return (m > top) ? top : t_q'(0) - m;
        return (m > top - 1) ? top - 1 : m;
    endfunction

    function automatic t_q q_minus(t_q a, t_q b);
        logic sa, sb;
        t_q ma, mb;
        logic [64:0] s;
        sa = a[63];
        sb = ~b[63];
        ma = q_mag(a);
        mb = q_mag(b);
        if (sa == sb) begin
            s = {1'b0, ma} + {1'b0, mb};
            return q_pack(sa, s[64] ? '1 : s[63:0]);
        end
        if (ma >= mb) return q_pack(sa, ma - mb);
        return q_pack(sb, mb - ma);
    endfunction

    function automatic t_q q_mul(t_q a, t_q b);
        logic [127:0] p;
        p = {64'b0, q_mag(a)} * {64'b0, q_mag(b)};
        p = p >> 32;
        return q_pack(a[63] != b[63], (p[127:64] != 0) ? '1 : p[63:0]);
    endfunction

    function automatic t_q q_div(t_q a, t_q b);
        t_q ma, mb;
        logic [95:0] num, quo;
        ma = q_mag(a);
        mb = q_mag(b);
        if (mb == 0) return (ma == 0) ? t_q'(0) : q_pack(a[63], '1);
        num = {ma, 32'b0};
        quo = num / {32'b0, mb};
        return q_pack(a[63] != b[63], (quo[95:64] != 0) ? '1 : quo[63:0]);
    endfunction

    function automatic int rows_in_use();
        if (m_size < 3) return 3;
        if (m_size > NMAX) return NMAX;
        return int'(m_size);
    endfunction

    // thomas elimination; returns 1 when a pivot is too small
    function automatic logic solve_system();
        int  n;
        t_q  d, x;
        n = rows_in_use();
        if (q_mag(m_diag) < {1'b0, m_thresh}) return ctsu_pkg::STATUS_UNSTABLE;
        ratio_mem[0] = q_div(m_super, m_diag);
        partial_mem[0] = q_div(rhs_mem[0], m_diag);
        for (int i = 1; i + 1 < n; i++) begin
            d = q_minus(m_diag, q_mul(m_sub, ratio_mem[i-1]));
            if (q_mag(d) < {1'b0, m_thresh}) return ctsu_pkg::STATUS_UNSTABLE;
            ratio_mem[i] = q_div(m_super, d);
            partial_mem[i] = q_div(q_minus(rhs_mem[i], q_mul(m_sub, partial_mem[i-1])), d);
        end
        d = q_minus(m_diag, q_mul(m_sub, ratio_mem[n-2]));
        if (q_mag(d) < {1'b0, m_thresh}) return ctsu_pkg::STATUS_UNSTABLE;
        x = q_div(q_minus(m_bound, q_mul(m_sub, partial_mem[n-2])), d);
        sol_mem[n-1] = x;
        for (int i = n - 1; i > 0; i--) begin
            x = q_minus(partial_mem[i-1], q_mul(ratio_mem[i-1], x));
            sol_mem[i-1] = x;
        end
        return ctsu_pkg::STATUS_OK;
    endfunction

    // a solve may only touch rhs entries loaded since reset
    function automatic bit solve_allowed(int idx);
        int n;
        n = rows_in_use();
        for (int j = 0; j < n - 1; j++) begin
            if (!rhs_written[j] && j != idx) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_q rand_q();
        return {$urandom, $urandom};
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 6);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        ctsu_pkg::t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d status=%0d value=%h",
                       out_item.kind, out_item.status, out_item.solution_value);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_item.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
                    fail_count++;
                end
                if (out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_item.status);
                    fail_count++;
                end
                if (out_item.solution_value !== want.solution_value) begin
                    $error("solution_value: expected %h, got %h",
                           want.solution_value, out_item.solution_value);
                    fail_count++;
                end
            end
        end
    end

    task automatic issue_item(ctsu_pkg::t_in_item it, bit typed, ctsu_pkg::t_out_item fixed);
        ctsu_pkg::t_out_item res;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        res = '0;
        if (it.operation == ctsu_pkg::OP_READ) begin
            res.kind = ctsu_pkg::KIND_READ;
            res.status = ctsu_pkg::STATUS_OK;
            res.solution_value = sol_mem[it.index];
            pending_results.push_back(typed ? fixed : res);
        end else begin
            rhs_mem[it.index] = it.rhs_value;
            rhs_written[it.index] = 1'b1;
            if (it.last) begin
                res.kind = ctsu_pkg::KIND_SOLVED;
                res.status = solve_system();
                pending_results.push_back(typed ? fixed : res);
            end
        end
    endtask

    task automatic send(logic op, int idx, t_q val, logic lst);
        ctsu_pkg::t_in_item it;
        it.operation = op;
        it.index = idx[10:0];
        it.rhs_value = val;
        it.last = lst;
        issue_item(it, 1'b0, '0);
    endtask

    // stop sending until every transfer has come back and the block has settled
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, t_q data);
        drain();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            ctsu_pkg::CFG_COEF_SUB:       m_sub = data;
            ctsu_pkg::CFG_COEF_DIAG:      m_diag = data;
            ctsu_pkg::CFG_COEF_SUPER:     m_super = data;
            ctsu_pkg::CFG_LOWER_BOUNDARY: m_bound = data;
            ctsu_pkg::CFG_SIZE_IN_USE:    m_size = data[11:0];
            ctsu_pkg::CFG_PIVOT_THRESH:   m_thresh = data[62:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_item(logic op, int idx, t_q val, logic lst, bit typed,
                            logic k, logic st, t_q sv);
        t_row r;
        r = '0;
        r.item.operation = op;
        r.item.index = idx[10:0];
        r.item.rhs_value = val;
        r.item.last = lst;
        r.typed = typed;
        r.res.kind = k;
        r.res.status = st;
        r.res.solution_value = sv;
        stim_table.push_back(r);
    endtask

    task automatic add_cfg(logic [2:0] idx, t_q data);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_data = data;
        stim_table.push_back(r);
    endtask

    task automatic well_formed(int n);
        for (int i = 0; i < n; i++) begin
            send(ctsu_pkg::OP_LOAD, i, ($urandom_range(0, 3) == 0) ? rand_q()
                 : {{30{$urandom_range(0, 1) == 1}}, 2'($urandom), $urandom},
                 i == n - 1);
            rand_items++;
        end
    endtask

    task automatic random_config();
        int r;
        r = $urandom_range(0, 9);
        write_reg(ctsu_pkg::CFG_COEF_DIAG, (r == 0) ? rand_q()
                  : q_pack($urandom_range(0, 1), {30'b0, 2'($urandom_range(2, 3)), $urandom}));
        write_reg(ctsu_pkg::CFG_COEF_SUB, ($urandom_range(0, 9) == 0) ? rand_q()
                  : q_pack($urandom_range(0, 1), {32'b0, $urandom}));
        write_reg(ctsu_pkg::CFG_COEF_SUPER, ($urandom_range(0, 9) == 0) ? rand_q()
                  : q_pack($urandom_range(0, 1), {32'b0, $urandom}));
        write_reg(ctsu_pkg::CFG_LOWER_BOUNDARY, ($urandom_range(0, 1) == 0) ? rand_q()
                  : q_pack($urandom_range(0, 1), {28'b0, 4'($urandom), $urandom}));
        r = $urandom_range(0, 19);
        write_reg(ctsu_pkg::CFG_PIVOT_THRESH, (r == 0) ? t_q'(0) : (r == 1) ? rand_q()
                  : {32'b0, 32'($urandom_range(0, 1 << 20))});
        r = $urandom_range(0, 19);
        write_reg(ctsu_pkg::CFG_SIZE_IN_USE, (r < 3) ? t_q'($urandom_range(0, 2))
                  : (r < 6) ? t_q'($urandom_range(9, 40)) : t_q'($urandom_range(3, 8)));
    endtask

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_row r;
        int   phase, idx, pick;
        m_sub = '0;
        m_diag = 64'h1_0000_0000;
        m_super = '0;
        m_bound = '0;
        m_size = 12'd2048;
        m_thresh = 63'd1;
        for (int i = 0; i < NMAX; i++) begin
            sol_mem[i] = '0;
            rhs_written[i] = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset contents, field extremes, unstable and zero-divisor solves
        add_item(ctsu_pkg::OP_READ, 0, '0, 1'b0, 1, ctsu_pkg::KIND_READ,
                 ctsu_pkg::STATUS_OK, '0);
        add_item(ctsu_pkg::OP_READ, 2047, '1, 1'b0, 1, ctsu_pkg::KIND_READ,
                 ctsu_pkg::STATUS_OK, '0);
        add_item(ctsu_pkg::OP_LOAD, 2047, 64'h7fff_ffff_ffff_ffff, 1'b0, 0, 0, 0, 0);
        add_item(ctsu_pkg::OP_LOAD, 1024, 64'h8000_0000_0000_0000, 1'b0, 0, 0, 0, 0);
        add_cfg(ctsu_pkg::CFG_SIZE_IN_USE, '0);
        add_cfg(ctsu_pkg::CFG_PIVOT_THRESH, 64'h7fff_ffff_ffff_ffff);
        add_item(ctsu_pkg::OP_LOAD, 0, 64'h1_0000_0000, 1'b0, 0, 0, 0, 0);
        add_item(ctsu_pkg::OP_LOAD, 1, 64'hffff_ffff_0000_0000, 1'b0, 0, 0, 0, 0);
        add_item(ctsu_pkg::OP_LOAD, 2, '0, 1'b1, 1, ctsu_pkg::KIND_SOLVED,
                 ctsu_pkg::STATUS_UNSTABLE, '0);
        add_cfg(ctsu_pkg::CFG_PIVOT_THRESH, '0);
        add_cfg(ctsu_pkg::CFG_COEF_DIAG, '0);
        add_item(ctsu_pkg::OP_LOAD, 2, 64'h5555_5555_5555_5555, 1'b1, 0, 0, 0, 0);
        add_item(ctsu_pkg::OP_READ, 0, '0, 1'b0, 0, 0, 0, 0);
        add_cfg(ctsu_pkg::CFG_COEF_DIAG, 64'h2_0000_0000);
        add_cfg(ctsu_pkg::CFG_COEF_SUB, 64'h8000_0000_0000_0000);
        add_cfg(ctsu_pkg::CFG_COEF_SUPER, 64'h7fff_ffff_ffff_ffff);
        add_cfg(ctsu_pkg::CFG_LOWER_BOUNDARY, 64'h8000_0000_0000_0000);
        add_item(ctsu_pkg::OP_LOAD, 2, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 0, 0, 0, 0);
        add_item(ctsu_pkg::OP_READ, 1, '0, 1'b0, 0, 0, 0, 0);
        add_cfg(ctsu_pkg::CFG_COEF_SUB, 64'hffff_ffff_8000_0000);
        add_cfg(ctsu_pkg::CFG_COEF_SUPER, 64'h0000_0000_4000_0000);
        add_cfg(ctsu_pkg::CFG_LOWER_BOUNDARY, 64'h1_0000_0000);
        add_cfg(ctsu_pkg::CFG_PIVOT_THRESH, 64'd1);
        add_item(ctsu_pkg::OP_LOAD, 0, 64'h3_0000_0000, 1'b1, 0, 0, 0, 0);
        for (int i = 0; i < 3; i++) add_item(ctsu_pkg::OP_READ, i, '0, 1'b0, 0, 0, 0, 0);

        foreach (stim_table[k]) begin
            r = stim_table[k];
            if (r.is_cfg) write_reg(r.cfg_idx, r.cfg_data);
            else issue_item(r.item, r.typed, r.res);
        end

        phase = 0;
        while (rand_items < 1000) begin
            random_config();
            repeat ($urandom_range(4, 10)) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    well_formed(rows_in_use());
                    repeat ($urandom_range(1, 3)) begin
                        send(ctsu_pkg::OP_READ, $urandom_range(0, rows_in_use() - 1), rand_q(),
                             $urandom_range(0, 1));
                        rand_items++;
                    end
                end else if (pick < 80) begin
                    send(ctsu_pkg::OP_READ, $urandom_range(0, NMAX - 1), rand_q(),
                         $urandom_range(0, 1));
                    rand_items++;
                end else begin
                    idx = $urandom_range(0, NMAX - 1);
                    send(ctsu_pkg::OP_LOAD, idx, rand_q(),
                         solve_allowed(idx) && $urandom_range(0, 1));
                    rand_items++;
                end
                if (phase == 1 && pick < 10) drain();
            end
            if (rand_items > 850) quiet = 1'b1;
            phase++;
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
